// ===== hw/rtl/rv32x_pkg.sv =====
// Shared types and constants for the RV32I execute unit.
`timescale 1ns / 1ps

package rv32x_pkg;

  localparam int unsigned XLEN       = 32;
  localparam int unsigned FUNC_W     = 5;
  localparam int unsigned IMM_W      = 21;
  localparam int unsigned SHAMT_W    = 5;
  localparam int unsigned ILEN_W     = 4;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [ILEN_W-1:0] ILEN_RESET = 4'd4;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_INSTR_LENGTH = 1'b0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD   = 5'd0,
    FUNC_SUB   = 5'd1,
    FUNC_SLL   = 5'd2,
    FUNC_SRL   = 5'd3,
    FUNC_SRA   = 5'd4,
    FUNC_SLT   = 5'd5,
    FUNC_SLTU  = 5'd6,
    FUNC_OR    = 5'd7,
    FUNC_XOR   = 5'd8,
    FUNC_AND   = 5'd9,
    FUNC_ADDI  = 5'd10,
    FUNC_SLLI  = 5'd11,
    FUNC_SRLI  = 5'd12,
    FUNC_SRAI  = 5'd13,
    FUNC_SLTI  = 5'd14,
    FUNC_SLTIU = 5'd15,
    FUNC_ORI   = 5'd16,
    FUNC_XORI  = 5'd17,
    FUNC_ANDI  = 5'd18,
    FUNC_LUI   = 5'd19,
    FUNC_AUIPC = 5'd20,
    FUNC_BEQ   = 5'd21,
    FUNC_BNE   = 5'd22,
    FUNC_BLT   = 5'd23,
    FUNC_BLTU  = 5'd24,
    FUNC_BGE   = 5'd25,
    FUNC_BGEU  = 5'd26,
    FUNC_JAL   = 5'd27,
    FUNC_JALR  = 5'd28
  } func_e;

  typedef struct packed {
    logic [FUNC_W-1:0]    func;
    logic [XLEN-1:0]      rs1_value;
    logic [XLEN-1:0]      rs2_value;
    logic [IMM_W-1:0]     immediate;
    logic [XLEN-1:0]      current_pc;
  } exec_req_t;

  typedef struct packed {
    logic [XLEN-1:0] rd_value;
    logic            write_rd;
    logic [XLEN-1:0] next_pc;
    logic            branch_taken;
    logic            illegal_imm;
  } exec_rsp_t;

endpackage

// ===== hw/rtl/rv32x_intf.sv =====
// Valid/ready channel interfaces for execute requests and results.
`timescale 1ns / 1ps

interface rv32x_req_if;
  import rv32x_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [FUNC_W-1:0]          func;
  logic signed [XLEN-1:0]     rs1_value;
  logic signed [XLEN-1:0]     rs2_value;
  logic signed [IMM_W-1:0]    immediate;
  logic [XLEN-1:0]            current_pc;

  modport source (output valid, func, rs1_value, rs2_value, immediate, current_pc,
                  input ready);
  modport sink   (input valid, func, rs1_value, rs2_value, immediate, current_pc,
                  output ready);
endinterface

interface rv32x_rsp_if;
  import rv32x_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [XLEN-1:0] rd_value;
  logic                   write_rd;
  logic [XLEN-1:0]        next_pc;
  logic                   branch_taken;
  logic                   illegal_imm;

  modport source (output valid, rd_value, write_rd, next_pc, branch_taken, illegal_imm,
                  input ready);
  modport sink   (input valid, rd_value, write_rd, next_pc, branch_taken, illegal_imm,
                  output ready);
endinterface

// ===== hw/rtl/rv32x_cfg.sv =====
// APB-style configuration register holding the instruction length.
`timescale 1ns / 1ps

module rv32x_cfg (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [rv32x_pkg::CFG_ADDR_W-1:0]    paddr_i,
  input  logic [rv32x_pkg::CFG_DATA_W-1:0]    pwdata_i,
  output logic [rv32x_pkg::CFG_DATA_W-1:0]    prdata_o,
  output logic                                pready_o,
  output logic [rv32x_pkg::ILEN_W-1:0]        instr_length_o
);
  import rv32x_pkg::*;

  logic [ILEN_W-1:0] instr_length_q;
  logic [ILEN_W-1:0] instr_length_d;
  logic              reg_sel;

  // Word-aligned decode: the byte offset bits are ignored.
  assign reg_sel  = (paddr_i[2] == REG_INSTR_LENGTH);
  assign pready_o = 1'b1;

  always_comb begin
    instr_length_d = instr_length_q;
    if (psel_i && penable_i && pwrite_i && reg_sel) begin
      instr_length_d = pwdata_i[ILEN_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      instr_length_q <= ILEN_RESET;
    end else begin
      instr_length_q <= instr_length_d;
    end
  end

  always_comb begin
    prdata_o = '0;
    if (reg_sel) begin
      prdata_o = {{(CFG_DATA_W-ILEN_W){1'b0}}, instr_length_q};
    end
  end

  assign instr_length_o = instr_length_q;

endmodule

// ===== hw/rtl/rv32x_alu.sv =====
// Combinational ALU, branch and jump logic for one instruction.
`timescale 1ns / 1ps

module rv32x_alu (
  input  rv32x_pkg::exec_req_t             req_i,
  input  logic [rv32x_pkg::ILEN_W-1:0]     instr_length_i,
  output rv32x_pkg::exec_rsp_t             rsp_o
);
  import rv32x_pkg::*;

  func_e              func;
  logic [XLEN-1:0]    op_a;
  logic [XLEN-1:0]    op_b;
  logic [XLEN-1:0]    imm32;
  logic [XLEN-1:0]    sum_ab;
  logic [XLEN-1:0]    diff_ab;
  logic [XLEN-1:0]    fall_pc;
  logic [XLEN-1:0]    target_pc;
  logic [XLEN-1:0]    upper_imm;
  logic [SHAMT_W-1:0] shamt;
  logic               imm_form;
  logic               imm_shift;
  logic               lt_s;
  logic               lt_u;
  logic               eq_ab;
  logic               alu_ok;
  logic               sh_ok;
  logic               up_ok;
  logic               br_ok;
  logic [XLEN-1:0]    alu_res;

  assign func  = func_e'(req_i.func);
  assign op_a  = req_i.rs1_value;
  assign imm32 = {{(XLEN-IMM_W){req_i.immediate[IMM_W-1]}}, req_i.immediate};

  assign imm_form  = func inside {FUNC_ADDI, FUNC_SLTI, FUNC_SLTIU, FUNC_ORI, FUNC_XORI,
                                  FUNC_ANDI, FUNC_JALR};
  assign imm_shift = func inside {FUNC_SLLI, FUNC_SRLI, FUNC_SRAI};

  assign op_b  = imm_form ? imm32 : req_i.rs2_value;
  assign shamt = imm_shift ? req_i.immediate[SHAMT_W-1:0] : req_i.rs2_value[SHAMT_W-1:0];

  // Range checks: the sign-extended value fits 12 bits, 13 bits, a shift
  // amount, or is a non-negative upper immediate.
  assign alu_ok = (&req_i.immediate[IMM_W-1:11]) || (~|req_i.immediate[IMM_W-1:11]);
  assign br_ok  = (&req_i.immediate[IMM_W-1:12]) || (~|req_i.immediate[IMM_W-1:12]);
  assign sh_ok  = ~|req_i.immediate[IMM_W-1:SHAMT_W];
  assign up_ok  = ~req_i.immediate[IMM_W-1];

  assign sum_ab    = op_a + op_b;
  assign diff_ab   = op_a - req_i.rs2_value;
  assign lt_s      = $signed(op_a) < $signed(op_b);
  assign lt_u      = op_a < op_b;
  assign eq_ab     = (op_a == req_i.rs2_value);
  assign fall_pc   = req_i.current_pc + {{(XLEN-ILEN_W){1'b0}}, instr_length_i};
  assign target_pc = req_i.current_pc + imm32;
  assign upper_imm = {imm32[XLEN-13:0], 12'b0};

  always_comb begin
    case (func)
      FUNC_ADD, FUNC_ADDI:               alu_res = sum_ab;
      FUNC_SUB:                          alu_res = diff_ab;
      FUNC_SLL, FUNC_SLLI:               alu_res = op_a << shamt;
      FUNC_SRL, FUNC_SRLI:               alu_res = op_a >> shamt;
      FUNC_SRA, FUNC_SRAI:               alu_res = $unsigned($signed(op_a) >>> shamt);
      FUNC_SLT, FUNC_SLTI:               alu_res = {{(XLEN-1){1'b0}}, lt_s};
      FUNC_SLTU, FUNC_SLTIU:             alu_res = {{(XLEN-1){1'b0}}, lt_u};
      FUNC_OR, FUNC_ORI:                 alu_res = op_a | op_b;
      FUNC_XOR, FUNC_XORI:               alu_res = op_a ^ op_b;
      FUNC_AND, FUNC_ANDI:               alu_res = op_a & op_b;
      FUNC_LUI:                          alu_res = upper_imm;
      FUNC_AUIPC:                        alu_res = upper_imm + req_i.current_pc;
      FUNC_JAL, FUNC_JALR:               alu_res = fall_pc;
      default:                           alu_res = '0;
    endcase
  end

  always_comb begin
    rsp_o.rd_value     = '0;
    rsp_o.write_rd     = 1'b0;
    rsp_o.next_pc      = fall_pc;
    rsp_o.branch_taken = 1'b0;
    rsp_o.illegal_imm  = 1'b0;
    case (func)
      FUNC_ADD, FUNC_SUB, FUNC_SLL, FUNC_SRL, FUNC_SRA, FUNC_SLT, FUNC_SLTU,
      FUNC_OR, FUNC_XOR, FUNC_AND: begin
        rsp_o.rd_value = alu_res;
        rsp_o.write_rd = 1'b1;
      end
      FUNC_ADDI, FUNC_SLTI, FUNC_SLTIU, FUNC_ORI, FUNC_XORI, FUNC_ANDI: begin
        if (alu_ok) begin
          rsp_o.rd_value = alu_res;
          rsp_o.write_rd = 1'b1;
        end else begin
          rsp_o.illegal_imm = 1'b1;
        end
      end
      FUNC_SLLI, FUNC_SRLI, FUNC_SRAI: begin
        if (sh_ok) begin
          rsp_o.rd_value = alu_res;
          rsp_o.write_rd = 1'b1;
        end else begin
          rsp_o.illegal_imm = 1'b1;
        end
      end
      FUNC_LUI, FUNC_AUIPC: begin
        if (up_ok) begin
          rsp_o.rd_value = alu_res;
          rsp_o.write_rd = 1'b1;
        end else begin
          rsp_o.illegal_imm = 1'b1;
        end
      end
      FUNC_BEQ, FUNC_BNE, FUNC_BLT, FUNC_BLTU, FUNC_BGE, FUNC_BGEU: begin
        if (!br_ok) begin
          rsp_o.illegal_imm = 1'b1;
        end else if ((func == FUNC_BEQ  &&  eq_ab) || (func == FUNC_BNE  && !eq_ab) ||
                     (func == FUNC_BLT  &&  lt_s)  || (func == FUNC_BLTU &&  lt_u)  ||
                     (func == FUNC_BGE  && !lt_s)  || (func == FUNC_BGEU && !lt_u)) begin
          rsp_o.branch_taken = 1'b1;
          rsp_o.next_pc      = target_pc;
        end
      end
      FUNC_JAL: begin
        rsp_o.rd_value     = alu_res;
        rsp_o.write_rd     = 1'b1;
        rsp_o.branch_taken = 1'b1;
        rsp_o.next_pc      = target_pc;
      end
      FUNC_JALR: begin
        if (alu_ok) begin
          rsp_o.rd_value     = alu_res;
          rsp_o.write_rd     = 1'b1;
          rsp_o.branch_taken = 1'b1;
          rsp_o.next_pc      = {sum_ab[XLEN-1:1], 1'b0};
        end else begin
          rsp_o.illegal_imm = 1'b1;
        end
      end
      default: begin
        rsp_o.rd_value = '0;
      end
    endcase
  end

endmodule

// ===== hw/rtl/rv32i_execute_unit.sv =====
// Top level of the RV32I execute unit: input register, ALU, result register.
`timescale 1ns / 1ps

// Path: after its input transfer an instruction passes the input register,
//   then the result register, which presents the result; it waits there
//   until taken.
// Throughput: one instruction per cycle, limited only by the output side;
//   the input register refills in the same cycle the result register drains.
// Reset: rst_ni clears both valid flags and sets instr_length to 4; the
//   payload registers are not reset.
module rv32i_execute_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rv32x_req_if.sink                         in_i,
  rv32x_rsp_if.source                       out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rv32x_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rv32x_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rv32x_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready
);
  import rv32x_pkg::*;

  logic [ILEN_W-1:0] instr_length;

  // Input stage: holds the instruction being executed.
  logic      in_valid_q;
  logic      in_valid_d;
  exec_req_t in_req_q;
  exec_req_t in_req_d;

  // Result stage: holds the finished result until the consumer takes it.
  logic      out_valid_q;
  logic      out_valid_d;
  exec_rsp_t out_rsp_q;
  exec_rsp_t out_rsp_d;

  logic in_xfer;
  logic out_free;
  logic advance;

  rv32x_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_o      (prdata),
    .pready_o      (pready),
    .instr_length_o(instr_length)
  );

  rv32x_alu u_alu (
    .req_i         (in_req_q),
    .instr_length_i(instr_length),
    .rsp_o         (out_rsp_d)
  );

  // The result register is free when it is empty or is being drained this
  // cycle. The input stage moves forward whenever the result register is
  // free, and accepts a new transfer whenever it is empty or moving forward.
  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_comb begin
    in_req_d.func       = in_i.func;
    in_req_d.rs1_value  = in_i.rs1_value;
    in_req_d.rs2_value  = in_i.rs2_value;
    in_req_d.immediate  = in_i.immediate;
    in_req_d.current_pc = in_i.current_pc;
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.ready) begin
      in_valid_d = in_i.valid;
    end
    out_valid_d = out_valid_q;
    if (out_free) begin
      out_valid_d = in_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_req_q <= in_req_d;
    end
    if (advance) begin
      out_rsp_q <= out_rsp_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.rd_value     = out_rsp_q.rd_value;
  assign out_o.write_rd     = out_rsp_q.write_rd;
  assign out_o.next_pc      = out_rsp_q.next_pc;
  assign out_o.branch_taken = out_rsp_q.branch_taken;
  assign out_o.illegal_imm  = out_rsp_q.illegal_imm;

  // An instruction leaving the input stage always lands in the result stage.
  a_advance_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("instruction lost between input and result stage");

  // With both stages full and the output stalled, no new transfer is taken.
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while pipeline is full and stalled");

  // An illegal immediate never writes the register file or redirects the pc.
  a_illegal_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_rsp_q.illegal_imm) |-> (!out_rsp_q.write_rd &&
                                                !out_rsp_q.branch_taken))
    else $error("illegal immediate produced a write or a redirect");

  // A taken jalr always has an even target.
  a_jalr_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && in_req_q.func == FUNC_JALR && out_rsp_d.branch_taken)
      |-> !out_rsp_d.next_pc[0])
    else $error("jalr target has bit zero set");

endmodule

// ===== test/rv32i_execute_unit_checker.sv =====
// RV32I execute unit checker: predicts and compares every result and length read.
`timescale 1ns / 1ps

module rv32i_execute_unit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  rv32x_req_if                             instr_i,
  rv32x_rsp_if                             result_i,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rv32x_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [rv32x_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [rv32x_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                             pready,
  output int                               errors_o,
  output int                               outstanding_o
);
  import rv32x_pkg::*;

  logic [ILEN_W-1:0] instr_len;
  exec_rsp_t         pending_results[$];
  int                fail_count = 0;

  function automatic exec_rsp_t predict_exec(exec_req_t req, logic [ILEN_W-1:0] ilen);
    logic [XLEN-1:0]        a, b, imm, pc, fall;
    logic signed [XLEN-1:0] simm;
    logic                   alu_ok, sh_ok, up_ok, br_ok, cond;
    exec_rsp_t              rsp;
    a      = req.rs1_value;
    b      = req.rs2_value;
    pc     = req.current_pc;
    imm    = {{(XLEN-IMM_W){req.immediate[IMM_W-1]}}, req.immediate};
    simm   = $signed(imm);
    fall   = pc + {{(XLEN-ILEN_W){1'b0}}, ilen};
    alu_ok = (simm >= -2048) && (simm <= 2047);
    sh_ok  = (imm <= 32'd31);
    up_ok  = !req.immediate[IMM_W-1];
    br_ok  = (simm >= -4096) && (simm <= 4095);
    cond   = 1'b0;
    rsp         = '0;
    rsp.next_pc = fall;
    case (req.func)
      FUNC_ADD, FUNC_SUB, FUNC_SLL, FUNC_SRL, FUNC_SRA, FUNC_SLT, FUNC_SLTU,
      FUNC_OR, FUNC_XOR, FUNC_AND: begin
        rsp.write_rd = 1'b1;
        case (req.func)
          FUNC_ADD:  rsp.rd_value = a + b;
          FUNC_SUB:  rsp.rd_value = a - b;
          FUNC_SLL:  rsp.rd_value = a << b[SHAMT_W-1:0];
          FUNC_SRL:  rsp.rd_value = a >> b[SHAMT_W-1:0];
          FUNC_SRA:  rsp.rd_value = $signed(a) >>> b[SHAMT_W-1:0];
          FUNC_SLT:  rsp.rd_value = {31'b0, $signed(a) < $signed(b)};
          FUNC_SLTU: rsp.rd_value = {31'b0, a < b};
          FUNC_OR:   rsp.rd_value = a | b;
          FUNC_XOR:  rsp.rd_value = a ^ b;
          default:   rsp.rd_value = a & b;
        endcase
      end
      FUNC_ADDI, FUNC_SLTI, FUNC_SLTIU, FUNC_ORI, FUNC_XORI, FUNC_ANDI: begin
        if (!alu_ok) begin
          rsp.illegal_imm = 1'b1;
        end else begin
          rsp.write_rd = 1'b1;
          case (req.func)
            FUNC_ADDI:  rsp.rd_value = a + imm;
            FUNC_SLTI:  rsp.rd_value = {31'b0, $signed(a) < simm};
            FUNC_SLTIU: rsp.rd_value = {31'b0, a < imm};
            FUNC_ORI:   rsp.rd_value = a | imm;
            FUNC_XORI:  rsp.rd_value = a ^ imm;
            default:    rsp.rd_value = a & imm;
          endcase
        end
      end
      FUNC_SLLI, FUNC_SRLI, FUNC_SRAI: begin
        if (!sh_ok) begin
          rsp.illegal_imm = 1'b1;
        end else begin
          rsp.write_rd = 1'b1;
          case (req.func)
            FUNC_SLLI: rsp.rd_value = a << imm[SHAMT_W-1:0];
            FUNC_SRLI: rsp.rd_value = a >> imm[SHAMT_W-1:0];
            default:   rsp.rd_value = $signed(a) >>> imm[SHAMT_W-1:0];
          endcase
        end
      end
      FUNC_LUI, FUNC_AUIPC: begin
        if (!up_ok) begin
          rsp.illegal_imm = 1'b1;
        end else begin
          rsp.write_rd = 1'b1;
          rsp.rd_value = {imm[19:0], 12'b0} + ((req.func == FUNC_AUIPC) ? pc : '0);
        end
      end
      FUNC_BEQ, FUNC_BNE, FUNC_BLT, FUNC_BLTU, FUNC_BGE, FUNC_BGEU: begin
        if (!br_ok) begin
          rsp.illegal_imm = 1'b1;
        end else begin
          case (req.func)
            FUNC_BEQ:  cond = (a == b);
            FUNC_BNE:  cond = (a != b);
            FUNC_BLT:  cond = $signed(a) < $signed(b);
            FUNC_BLTU: cond = a < b;
            FUNC_BGE:  cond = !($signed(a) < $signed(b));
            default:   cond = a >= b;
          endcase
          if (cond) begin
            rsp.branch_taken = 1'b1;
            rsp.next_pc      = pc + imm;
          end
        end
      end
      FUNC_JAL: begin
        rsp.rd_value     = fall;
        rsp.write_rd     = 1'b1;
        rsp.branch_taken = 1'b1;
        rsp.next_pc      = pc + imm;
      end
      FUNC_JALR: begin
        if (!alu_ok) begin
          rsp.illegal_imm = 1'b1;
        end else begin
          rsp.rd_value     = fall;
          rsp.write_rd     = 1'b1;
          rsp.branch_taken = 1'b1;
          rsp.next_pc      = (a + imm) & ~32'd1;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic check_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
      fail_count++;
    end
  endtask

  // Everything is sampled at the rising edge; the result side is looked at
  // first so that a transfer arriving in the same cycle cannot be matched.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    exec_req_t instr;
    exec_rsp_t want;
    if (!rst_ni) begin
      instr_len <= ILEN_RESET;
    end else begin
      if (result_i.valid && result_i.ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with no result pending");
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          check_field("rd_value", want.rd_value, result_i.rd_value);
          check_field("write_rd", want.write_rd, result_i.write_rd);
          check_field("next_pc", want.next_pc, result_i.next_pc);
          check_field("branch_taken", want.branch_taken, result_i.branch_taken);
          check_field("illegal_imm", want.illegal_imm, result_i.illegal_imm);
        end
      end
      if (instr_i.valid && instr_i.ready) begin
        instr.func       = instr_i.func;
        instr.rs1_value  = instr_i.rs1_value;
        instr.rs2_value  = instr_i.rs2_value;
        instr.immediate  = instr_i.immediate;
        instr.current_pc = instr_i.current_pc;
        pending_results.push_back(predict_exec(instr, instr_len));
      end
      if (psel && penable && pready && paddr[2] == REG_INSTR_LENGTH) begin
        if (pwrite) begin
          instr_len <= pwdata[ILEN_W-1:0];
        end else begin
          check_field("instr_length", {{(CFG_DATA_W-ILEN_W){1'b0}}, instr_len}, prdata);
        end
      end
      errors_o      <= fail_count;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

// ===== test/rv32i_execute_unit_tb.sv =====
// Testbench top for the RV32I execute unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rv32i_execute_unit_tb;
  import rv32x_pkg::*;

  // The only code outside the decoded set that is exercised by name.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED_TOP = 5'd31;
  // Byte address of the instruction length register.
  localparam logic [CFG_ADDR_W-1:0] ADDR_INSTR_LENGTH = {REG_INSTR_LENGTH, 2'b00};
  localparam int RANDOM_PER_PHASE = 120;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // Set for the closing phase, in which neither side idles.
  bit quiet;
  int fail_count;
  int results_pending;

  rv32x_req_if in_if ();
  rv32x_rsp_if out_if ();

  rv32i_execute_unit dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  rv32i_execute_unit_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .instr_i       (in_if),
    .result_i      (out_if),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .errors_o      (fail_count),
    .outstanding_o (results_pending)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // Hard stop in case a handshake never completes. The slowest legal run is
  // well under a tenth of this.
  initial begin
    #1_000_000;
    $display("rv32i_execute_unit_tb: done, errors");
    $finish;
  end

  function automatic exec_req_t mk_instr(logic [FUNC_W-1:0] f, logic [XLEN-1:0] a,
                                         logic [XLEN-1:0] b, int imm,
                                         logic [XLEN-1:0] pc);
    exec_req_t req;
    req.func       = f;
    req.rs1_value  = a;
    req.rs2_value  = b;
    req.immediate  = IMM_W'(imm);
    req.current_pc = pc;
    return req;
  endfunction

  // Register values lean toward the corners where sign and carry matter.
  function automatic logic [XLEN-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'hffff_ffff;
      2:       return 32'h8000_0000;
      3:       return 32'h7fff_ffff;
      4:       return $urandom_range(0, 64);
      default: return $urandom;
    endcase
  endfunction

  // Most immediates sit inside the legal range of their operation so that
  // the operation itself is exercised. A share hits the range borders, and
  // another share is fully random, which mostly lands out of range.
  function automatic exec_req_t random_instr();
    int             imm_corners[14] = '{-2049, -2048, -1, 0, 31, 32, 2047, 2048,
                                        -4097, -4096, 4095, 4096, 1048575, -1048576};
    int             pick;
    exec_req_t      req;
    logic [XLEN-1:0] a;
    if ($urandom_range(0, 99) < 3) begin
      req.func = FUNC_W'($urandom_range(29, 31));
    end else begin
      req.func = FUNC_W'($urandom_range(0, 28));
    end
    a             = pick_word();
    req.rs1_value = a;
    // Equal operands are needed to reach the equality side of the branches.
    req.rs2_value = ($urandom_range(0, 3) == 0) ? a : pick_word();
    req.current_pc = ($urandom_range(0, 15) == 0) ? 32'hffff_fff0 | $urandom_range(0, 15)
                                                  : $urandom;
    pick = $urandom_range(0, 15);
    if (pick == 0) begin
      req.immediate = IMM_W'($urandom);
    end else if (pick == 1) begin
      req.immediate = IMM_W'(imm_corners[$urandom_range(0, 13)]);
    end else begin
      case (req.func)
        FUNC_ADDI, FUNC_SLTI, FUNC_SLTIU, FUNC_ORI, FUNC_XORI, FUNC_ANDI, FUNC_JALR:
          req.immediate = IMM_W'(int'($urandom_range(0, 4095)) - 2048);
        FUNC_SLLI, FUNC_SRLI, FUNC_SRAI:
          req.immediate = IMM_W'($urandom_range(0, 31));
        FUNC_LUI, FUNC_AUIPC:
          req.immediate = IMM_W'($urandom_range(0, 1048575));
        FUNC_BEQ, FUNC_BNE, FUNC_BLT, FUNC_BLTU, FUNC_BGE, FUNC_BGEU:
          req.immediate = IMM_W'(int'($urandom_range(0, 8191)) - 4096);
        default:
          req.immediate = IMM_W'($urandom);
      endcase
    end
    return req;
  endfunction

  // Offers one instruction and returns at the edge where it is transferred.
  // Outside the closing phase an idle gap may come first; valid is only
  // lowered when such a gap is taken.
  task automatic send_instr(exec_req_t req);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= req.func;
    in_if.rs1_value  <= req.rs1_value;
    in_if.rs2_value  <= req.rs2_value;
    in_if.immediate  <= req.immediate;
    in_if.current_pc <= req.current_pc;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // One APB transfer: setup cycle, then access cycle until pready. The bus
  // is left idle afterwards.
  task automatic apb_transfer(logic wr, logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_INSTR_LENGTH;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Waits until every predicted result has come out, then lets the two
  // pipeline stages settle. The first edge lets the checker's count catch
  // up with a transfer made at the calling edge.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write the length register, then read it back for the checker.
  task automatic set_instr_length(logic [ILEN_W-1:0] len);
    apb_transfer(1'b1, {{(CFG_DATA_W-ILEN_W){1'b0}}, len});
    apb_transfer(1'b0, '0);
  endtask

  // Result side: stalls, short and long runs of ready, and a steady ready in
  // the closing phase. A stall still running when the closing phase starts is
  // cut short.
  initial begin : result_ready_gen
    int mode;
    out_if.ready = 1'b0;
    @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 9);
        out_if.ready <= (mode >= 3);
        if (mode == 3) begin
          repeat ($urandom_range(40, 120)) @(posedge clk_i);
        end else begin
          repeat ($urandom_range(1, 18)) begin
            if (quiet) break;
            @(posedge clk_i);
          end
        end
      end
    end
  end

  initial begin : stimulus
    logic [ILEN_W-1:0] len_plan[6];
    in_if.valid      = 1'b0;
    in_if.func       = '0;
    in_if.rs1_value  = '0;
    in_if.rs2_value  = '0;
    in_if.immediate  = '0;
    in_if.current_pc = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    quiet            = 1'b0;
    rst_ni           = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The length register must read back its reset value of four.
    apb_transfer(1'b0, '0);

    // Directed part, with the reset instruction length. Every operation
    // appears once, AUIPC twice; corners are folded into the operands.
    send_instr(mk_instr(FUNC_ADD,   32'h7fff_ffff, 32'h0000_0001, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SUB,   32'h8000_0000, 32'h0000_0001, 0, 32'h0000_1000));
    // Register shifts use only the low five bits of the second operand.
    send_instr(mk_instr(FUNC_SLL,   32'h0000_0001, 32'hffff_ffff, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SRL,   32'h8000_0000, 32'h0000_0020, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SRA,   32'h8000_0000, 32'h0000_001f, 0, 32'h0000_1000));
    // Set-less-than writes a one when true and a zero when false.
    send_instr(mk_instr(FUNC_SLT,   32'hffff_ffff, 32'h0000_0001, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SLTU,  32'hffff_ffff, 32'h0000_0001, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_OR,    32'ha5a5_a5a5, 32'h0f0f_0f0f, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_XOR,   32'ha5a5_a5a5, 32'hffff_ffff, 0, 32'h0000_1000));
    send_instr(mk_instr(FUNC_AND,   32'ha5a5_a5a5, 32'h0f0f_0f0f, 0, 32'h0000_1000));
    // Immediate operations at and just past their borders: twelve bits or a shift amount.
    send_instr(mk_instr(FUNC_ADDI,  32'h0000_0000, 0, -2048, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SLLI,  32'h0000_0001, 0, 32, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SRLI,  32'h8000_0000, 0, 31, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SRAI,  32'h8000_0000, 0, -1, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SLTI,  32'h7fff_ffff, 0, 2047, 32'h0000_1000));
    send_instr(mk_instr(FUNC_SLTIU, 32'h0000_0005, 0, -1, 32'h0000_1000));
    send_instr(mk_instr(FUNC_ORI,   32'h0000_0005, 0, 2048, 32'h0000_1000));
    send_instr(mk_instr(FUNC_XORI,  32'h1234_5678, 0, -1, 32'h0000_1000));
    send_instr(mk_instr(FUNC_ANDI,  32'h1234_5678, 0, -2049, 32'h0000_1000));
    // Upper immediates: the largest legal value, a sum that wraps, and a negative one.
    send_instr(mk_instr(FUNC_LUI,   0, 0, 1048575, 32'h0000_1000));
    send_instr(mk_instr(FUNC_AUIPC, 0, 0, 1, 32'hffff_f000));
    send_instr(mk_instr(FUNC_AUIPC, 0, 0, -1, 32'h0000_1000));
    // Branches: taken at the lowest offset, out of range, signed against
    // unsigned order, and equality on the inclusive compare.
    send_instr(mk_instr(FUNC_BEQ,   32'h1234_5678, 32'h1234_5678, -4096, 32'h0000_1000));
    send_instr(mk_instr(FUNC_BNE,   32'h1234_5678, 32'h1234_5678, 4096, 32'h0000_1000));
    send_instr(mk_instr(FUNC_BLT,   32'h8000_0000, 32'h0000_0000, 4095, 32'h0000_1000));
    send_instr(mk_instr(FUNC_BLTU,  32'h8000_0000, 32'h0000_0000, 4095, 32'h0000_1000));
    send_instr(mk_instr(FUNC_BGE,   32'hffff_ffff, 32'hffff_ffff, 8, 32'h0000_1000));
    send_instr(mk_instr(FUNC_BGEU,  32'h0000_0000, 32'hffff_ffff, 8, 32'h0000_1000));
    // Jumps: the whole offset field wraps the pc; the jalr target drops bit 0.
    send_instr(mk_instr(FUNC_JAL,   0, 0, -1048576, 32'h0000_0000));
    send_instr(mk_instr(FUNC_JALR,  32'hffff_ffff, 0, 0, 32'h0000_1000));
    // An unused code acts as no operation, with a fall-through that wraps.
    send_instr(mk_instr(FUNC_UNUSED_TOP, 32'hffff_ffff, 32'hffff_ffff, -1, 32'hffff_fffc));

    repeat (RANDOM_PER_PHASE) send_instr(random_instr());

    // Middle phases sweep the length register, extremes and out-of-range
    // values included. Writes only happen once the block has drained.
    len_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'($urandom_range(2, 7))};
    foreach (len_plan[i]) begin
      drain();
      set_instr_length(len_plan[i]);
      repeat (RANDOM_PER_PHASE) send_instr(random_instr());
    end

    // Closing phase at the reset length, back to back on both sides.
    drain();
    set_instr_length(ILEN_RESET);
    quiet = 1'b1;
    repeat (100) send_instr(random_instr());
    drain();

    if (fail_count == 0) begin
      $display("rv32i_execute_unit_tb: done, clean");
    end else begin
      $display("rv32i_execute_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
